// File: rtl/core/skct_pkg.sv
// Shared types and constants of the sorted key counter table.
// Used by skct_engine and sorted_key_counter_table; depends on nothing.
package skct_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam int OP_W   = 2;
   localparam int KEY_W  = 64;
   localparam int ST_W   = 3;
   localparam int HIT_W  = 32;
   localparam int POS_W  = 8;
   localparam int OCC_W  = 9;

   localparam int REQ_DATA_W = 64;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 56;
   localparam int RSP_USER_W = 3;

   localparam logic [CNT_W-1:0] FULL_TOTAL = CNT_W'(TABLE_DEPTH);
   localparam logic [HIT_W-1:0] HIT_MAX    = '1;

   typedef enum logic [OP_W-1:0] {
      OP_INCR   = 2'd0,
      OP_INSERT = 2'd1,
      OP_LOOKUP = 2'd2
   } op_type;

   typedef enum logic [ST_W-1:0] {
      ST_INCREMENTED = 3'd0,
      ST_INSERTED    = 3'd1,
      ST_PRESENT     = 3'd2,
      ST_NOT_FOUND   = 3'd3,
      ST_FULL        = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SETUP,
      S_STEP,
      S_PROBE,
      S_SHIFT,
      S_PLACE,
      S_DONE
   } fsm_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [HIT_W-1:0] count;
   } entry_type;

   typedef struct packed {
      logic [ST_W-1:0]  status;
      logic [HIT_W-1:0] hit_count;
      logic [POS_W-1:0] entry_position;
      logic [OCC_W-1:0] occupancy;
   } result_type;

endpackage

// File: rtl/core/sorted_key_counter_table.sv
// Top level of the sorted key counter table: stream ports and result register.
// Instantiates skct_engine; depends on skct_pkg.
//
// Use: each request beat carries an opcode in req_tuser (increment-or-insert,
// insert only, lookup) and a 64-bit key in req_tdata. Every request gives
// exactly one response beat: status in rsp_tuser, counter, sorted position
// and table occupancy in rsp_tdata. Keys live in ascending order in a single
// 256-entry memory (key and count side by side, one read and one write port,
// registered read data). A lookup is a lower-bound binary search, one
// memory read per step, up to nine steps on a full table.
// The pace is set by the search loop through the memory read port. An insert
// also moves each entry above the insert point up by one through the same port,
// then places the key. The engine takes one request at a time.
// The response sits in an output register: the engine takes the next request
// while it waits. When rsp_tready stays low the engine finishes its item and
// then holds it, and req_tready stays low until the register frees up.
// Reset empties the table at once (entry total to zero); no clearing pass.
module sorted_key_counter_table
   import skct_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [63:0] key_hash
   input  logic [REQ_USER_W-1:0] req_tuser,  // [1:0] opcode
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // [31:0] hit_count, [39:32] entry_position,
                                             // [48:40] occupancy, [55:49] zero
   output logic [RSP_USER_W-1:0] rsp_tuser   // [2:0] status
);

   logic       eng_valid, eng_ready, load;
   result_type eng_res;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;

   skct_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_opcode (req_tuser[OP_W-1:0]),
      .in_key    (req_tdata[KEY_W-1:0]),
      .res_valid (eng_valid),
      .res_ready (eng_ready),
      .res       (eng_res)
   );

   // take a finished result whenever the output register is empty or draining
   assign eng_ready = !rsp_valid_ff || rsp_tready;
   assign load      = eng_valid && eng_ready;

   always_comb begin
      rsp_in       = load ? eng_res : rsp_ff;
      rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: no reset needed
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {(RSP_DATA_W - OCC_W - POS_W - HIT_W)'(0),
                        rsp_ff.occupancy, rsp_ff.entry_position, rsp_ff.hit_count};

endmodule

// File: rtl/core/skct_engine.sv
// Search, update and insert engine of the sorted key counter table.
// Holds the key/count memory and the entry total; depends on skct_pkg.
module skct_engine
   import skct_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [OP_W-1:0]  in_opcode,
   input  logic [KEY_W-1:0] in_key,
   output logic             res_valid,
   input  logic             res_ready,
   output result_type       res
);

   entry_type mem [TABLE_DEPTH];
   entry_type rd_data_ff;

   fsm_type state_ff, state_in;

   logic [OP_W-1:0]  op_ff, op_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0] lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [CNT_W-1:0] src_ff, src_in, total_ff, total_in;
   result_type       res_ff, res_in;

   logic             rd_en, wr_en;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   entry_type        wr_data;

   logic             key_less, found, can_insert, table_full;
   logic [CNT_W-1:0] lo_step, hi_step, mid_step, mid_init;
   logic [HIT_W-1:0] count_next;

   // search step arithmetic
   always_comb begin
      key_less   = rd_data_ff.key < key_ff;
      lo_step    = key_less ? (mid_ff + CNT_W'(1)) : lo_ff;
      hi_step    = key_less ? hi_ff : mid_ff;
      mid_step   = lo_step + ((hi_step - lo_step) >> 1);
      mid_init   = lo_ff + ((hi_ff - lo_ff) >> 1);
      found      = (lo_ff < total_ff) && (rd_data_ff.key == key_ff);
      can_insert = (op_ff == OP_INCR) || (op_ff == OP_INSERT);
      table_full = total_ff == FULL_TOTAL;
      count_next = (rd_data_ff.count == HIT_MAX) ? HIT_MAX
                                                 : rd_data_ff.count + HIT_W'(1);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (in_valid) state_in = S_SETUP;
         S_SETUP: state_in = (lo_ff < hi_ff) ? S_STEP : S_PROBE;
         S_STEP:  state_in = (lo_step < hi_step) ? S_STEP : S_PROBE;
         S_PROBE: begin
            priority if (found || !can_insert || table_full) state_in = S_DONE;
            else if (lo_ff == total_ff)                      state_in = S_PLACE;
            else                                              state_in = S_SHIFT;
         end
         S_SHIFT: state_in = (src_ff == lo_ff) ? S_PLACE : S_SHIFT;
         S_PLACE: state_in = S_DONE;
         S_DONE:  if (res_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      op_in    = op_ff;
      key_in   = key_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      mid_in   = mid_ff;
      src_in   = src_ff;
      total_in = total_ff;
      res_in   = res_ff;
      rd_en    = 1'b0;
      rd_addr  = lo_ff[IDX_W-1:0];
      wr_en    = 1'b0;
      wr_addr  = lo_ff[IDX_W-1:0];
      wr_data  = rd_data_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               op_in  = in_opcode;
               key_in = in_key;
               lo_in  = '0;
               hi_in  = total_ff;
            end
         end
         S_SETUP: begin
            rd_en = 1'b1;
            if (lo_ff < hi_ff) begin
               mid_in  = mid_init;
               rd_addr = mid_init[IDX_W-1:0];
            end
         end
         S_STEP: begin
            lo_in = lo_step;
            hi_in = hi_step;
            rd_en = 1'b1;
            if (lo_step < hi_step) begin
               mid_in  = mid_step;
               rd_addr = mid_step[IDX_W-1:0];
            end else begin
               rd_addr = lo_step[IDX_W-1:0];
            end
         end
         S_PROBE: begin
            res_in.status         = ST_NOT_FOUND;
            res_in.hit_count      = '0;
            res_in.entry_position = '0;
            res_in.occupancy      = OCC_W'(total_ff);
            priority if (found) begin
               res_in.entry_position = POS_W'(lo_ff);
               if (op_ff == OP_INCR) begin
                  wr_en             = 1'b1;
                  wr_data.key       = key_ff;
                  wr_data.count     = count_next;
                  res_in.status     = ST_INCREMENTED;
                  res_in.hit_count  = count_next;
               end else begin
                  res_in.status     = ST_PRESENT;
                  res_in.hit_count  = rd_data_ff.count;
               end
            end else if (can_insert && table_full) begin
               res_in.status = ST_FULL;
            end else if (can_insert && (lo_ff != total_ff)) begin
               // open the gap: start from the top entry
               rd_en   = 1'b1;
               src_in  = total_ff - CNT_W'(1);
               rd_addr = src_in[IDX_W-1:0];
            end else begin
               res_in.status = ST_NOT_FOUND;
            end
         end
         S_SHIFT: begin
            // move the entry read last cycle up by one, fetch the next lower
            wr_en   = 1'b1;
            wr_addr = IDX_W'(src_ff + CNT_W'(1));
            wr_data = rd_data_ff;
            if (src_ff != lo_ff) begin
               rd_en   = 1'b1;
               src_in  = src_ff - CNT_W'(1);
               rd_addr = src_in[IDX_W-1:0];
            end
         end
         S_PLACE: begin
            wr_en                 = 1'b1;
            wr_addr               = lo_ff[IDX_W-1:0];
            wr_data.key           = key_ff;
            wr_data.count         = '0;
            total_in              = total_ff + CNT_W'(1);
            res_in.status         = ST_INSERTED;
            res_in.hit_count      = '0;
            res_in.entry_position = POS_W'(lo_ff);
            res_in.occupancy      = OCC_W'(total_in);
         end
         S_DONE: begin
         end
         default: begin
         end
      endcase
   end

   assign in_ready  = state_ff == S_IDLE;
   assign res_valid = state_ff == S_DONE;
   assign res       = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         total_ff <= '0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      key_ff <= key_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      mid_ff <= mid_in;
      src_ff <= src_in;
      res_ff <= res_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= FULL_TOTAL)
      else $error("entry total beyond table depth");

   a_search_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STEP) |-> (lo_ff <= mid_ff) && (mid_ff < hi_ff) && (hi_ff <= total_ff))
      else $error("search window out of order");

   a_shift_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) |-> (src_ff >= lo_ff) && (src_ff < total_ff) && !table_full)
      else $error("shift source outside the moved range");

   a_place_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PLACE) |=> (total_ff == $past(total_ff) + CNT_W'(1)))
      else $error("insert did not grow the table");

   a_total_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_PLACE) |=> (total_ff == $past(total_ff)))
      else $error("entry total changed outside an insert");

endmodule

// File: bench/sorted_key_counter_table_test.sv
// Self-checking bench for sorted_key_counter_table: stream driver, response monitor and a
// scoreboard that mirrors the sorted table, its counters and its occupancy.
// Depends on skct_pkg and the sorted_key_counter_table RTL only.
module sorted_key_counter_table_test;
   import skct_pkg::*;

   localparam int          POOL_SIZE   = 300;
   localparam int          SETTLE      = 400;        // longest insert shift plus search
   localparam int unsigned CYCLE_LIMIT = 2_000_000;
   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;       // unused code, behaves as lookup

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [KEY_W-1:0] key;
   } request_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // [63:0] key_hash
   logic [REQ_USER_W-1:0] req_tuser  = '0;  // [1:0] opcode
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // [31:0] hit_count, [39:32] entry_position,
                                            // [48:40] occupancy, [55:49] zero
   logic [RSP_USER_W-1:0] rsp_tuser;        // [2:0] status

   sorted_key_counter_table u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Shadow of the table: keys in ascending order below held_total, each with its counter.
   logic [KEY_W-1:0] held_keys [TABLE_DEPTH];
   logic [HIT_W-1:0] held_hits [TABLE_DEPTH];
   int unsigned      held_total = 0;

   request_type pending_requests [$];   // beats still to be offered by the driver
   result_type  awaited_results  [$];   // responses predicted but not yet seen
   logic [KEY_W-1:0] key_pool [POOL_SIZE];

   request_type outgoing;
   result_type  predicted;
   result_type  oldest;
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   int          mismatches     = 0;
   int unsigned cycles         = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   // Lower-bound search over the shadow table, then apply the opcode the way the block
   // must: raise a counter (saturating), insert in sorted position, or only report.
   task automatic tally_key(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                            output result_type res);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      bit          hit;
      lo  = 0;
      hi  = held_total;
      res = '0;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (held_keys[mid] < key) begin
            lo = mid + 1;
         end else begin
            hi = mid;
         end
      end
      hit = (lo < held_total) && (held_keys[lo] == key);
      if (hit) begin
         res.entry_position = POS_W'(lo);
         if (op == OP_INCR) begin
            if (held_hits[lo] != HIT_MAX) held_hits[lo] = held_hits[lo] + 1'b1;
            res.status = ST_INCREMENTED;
         end else begin
            // insert only, lookup and the spare code all just report the entry
            res.status = ST_PRESENT;
         end
         res.hit_count = held_hits[lo];
      end else if (op == OP_INCR || op == OP_INSERT) begin
         if (held_total >= TABLE_DEPTH) begin
            res.status = ST_FULL;
         end else begin
            // shift the upper entries up by one and place the key with a zero counter
            for (int i = held_total; i > lo; i--) begin
               held_keys[i] = held_keys[i-1];
               held_hits[i] = held_hits[i-1];
            end
            held_keys[lo]      = key;
            held_hits[lo]      = '0;
            held_total         = held_total + 1;
            res.entry_position = POS_W'(lo);
            res.status         = ST_INSERTED;
         end
      end else begin
         res.status = ST_NOT_FOUND;
      end
      res.occupancy = OCC_W'(held_total);
   endtask

   function automatic void push_request(input logic [OP_W-1:0] op,
                                        input logic [KEY_W-1:0] key);
      request_type r;
      r.op  = op;
      r.key = key;
      pending_requests.push_back(r);
   endfunction

   // Mostly pool keys so that hits and a full table are reached; some fresh keys and
   // near neighbours of pool keys to probe the search boundaries.
   function automatic logic [KEY_W-1:0] pick_key();
      int unsigned      r;
      logic [KEY_W-1:0] k;
      r = $urandom_range(99);
      k = key_pool[$urandom_range(POOL_SIZE - 1)];
      if (r < 10) begin
         k = {$urandom, $urandom};
      end else if (r < 14) begin
         k = k + 64'd1;
      end else if (r < 18) begin
         k = k - 64'd1;
      end
      return k;
   endfunction

   function automatic logic [OP_W-1:0] pick_op();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 50) return OP_INCR;
      if (r < 70) return OP_INSERT;
      if (r < 94) return OP_LOOKUP;
      return OP_SPARE;
   endfunction

   // Hold off the sender until every request has been answered.
   task automatic drain();
      while (pending_requests.size() != 0 || req_tvalid || awaited_results.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (count) push_request(pick_op(), pick_key());
      drain();
   endtask

   // Driver: offer the next beat once the current one has been taken, idling at random.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            outgoing = pending_requests.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= outgoing.key;
            req_tuser  <= outgoing.op;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver back-pressure: stall at random according to the current phase.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Monitor: predict on every accepted request beat, check every accepted response beat
   // against the oldest prediction.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            tally_key(req_tuser, req_tdata, predicted);
            awaited_results.push_back(predicted);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_results.size() == 0) begin
               $error("response beat with no request outstanding: status %0d", rsp_tuser);
               mismatches++;
            end else begin
               oldest = awaited_results.pop_front();
               if (rsp_tuser !== oldest.status) begin
                  $error("status: expected %0d, actual %0d", oldest.status, rsp_tuser);
                  mismatches++;
               end
               if (rsp_tdata[31:0] !== oldest.hit_count) begin
                  $error("hit_count: expected %0d, actual %0d",
                         oldest.hit_count, rsp_tdata[31:0]);
                  mismatches++;
               end
               if (rsp_tdata[39:32] !== oldest.entry_position) begin
                  $error("entry_position: expected %0d, actual %0d",
                         oldest.entry_position, rsp_tdata[39:32]);
                  mismatches++;
               end
               if (rsp_tdata[48:40] !== oldest.occupancy) begin
                  $error("occupancy: expected %0d, actual %0d",
                         oldest.occupancy, rsp_tdata[48:40]);
                  mismatches++;
               end
               if (rsp_tdata[55:49] !== '0) begin
                  $error("padding: expected 0, actual %0d", rsp_tdata[55:49]);
                  mismatches++;
               end
            end
         end
      end
   end

   // Watchdog: stop a hung run well beyond the slowest legal one.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("sorted_key_counter_table_test failed");
         $finish;
      end
   end

   initial begin
      key_pool[0] = '0;
      key_pool[1] = '1;
      key_pool[2] = 64'd1;
      key_pool[3] = 64'h8000_0000_0000_0000;
      key_pool[4] = 64'h7FFF_FFFF_FFFF_FFFF;
      for (int i = 5; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed opening, no idling on either side.
      push_request(OP_LOOKUP, '0);                      // lookup on an empty table
      push_request(OP_SPARE, 64'd5);                    // spare code acts as lookup
      push_request(OP_INCR, '0);                        // first sighting inserts, no raise
      push_request(OP_INCR, '1);                        // largest key goes to the top
      push_request(OP_INCR, '0);                        // second sighting raises
      push_request(OP_INSERT, '0);                      // insert only of a present key
      push_request(OP_LOOKUP, '1);                      // lookup of a present key
      push_request(OP_INSERT, 64'h8000_0000_0000_0000); // insert in the middle
      push_request(OP_INCR, 64'h8000_0000_0000_0000);
      push_request(OP_SPARE, '1);                       // spare code on a present key
      push_request(OP_LOOKUP, 64'h0000_0000_0000_1234); // lookup of an absent key
      push_request(OP_INSERT, 64'd1);                   // insert low, entries shift up
      push_request(OP_INCR, '1);
      push_request(OP_INCR, '1);
      push_request(OP_INSERT, 64'h7FFF_FFFF_FFFF_FFFF);
      push_request(OP_INCR, 64'h7FFF_FFFF_FFFF_FFFE);   // neighbour, not a match
      push_request(OP_INCR, '0);
      push_request(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFE);
      push_request(OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA);
      push_request(OP_INCR, 64'h5555_5555_5555_5555);
      push_request(OP_LOOKUP, 64'h5555_5555_5555_5555);
      drain();

      // Random phases; the table fills to capacity early on and stays full, so later
      // phases see full-table refusals alongside hits and counter increments.
      run_phase(0, 0, 360);
      run_phase(46, 0, 360);
      run_phase(0, 46, 360);
      run_phase(16, 16, 360);

      repeat (SETTLE) @(negedge clock);
      if (mismatches == 0 && awaited_results.size() == 0) begin
         $display("sorted_key_counter_table_test passed");
      end else begin
         $display("sorted_key_counter_table_test failed");
      end
      $finish;
   end

endmodule
